// ===== rtl/lzhm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzhm_pkg
// Shared types and constants of the parallel hash matcher.
// ----------------------------------------------------------------------------
package lzhm_pkg;

    localparam int SUBSTRINGS       = 8;
    localparam int WINDOW_BYTES     = 16;
    localparam int TABLE_ENTRIES    = 4096;
    localparam int HASH_W           = 12;
    localparam logic [HASH_W-1:0] HASH_MASK = 12'hfff;
    localparam int MIN_MATCH        = 3;
    localparam int POS_W            = 32;
    localparam int DIST_W           = 16;
    localparam int LEN_W            = 8;
    localparam int SUB_IDX_W        = 3;

    localparam int DEF_SUBSTRING_BYTES = 8;
    localparam int DEF_BANK_COUNT      = 16;

    localparam logic [31:0] RESET_INPUT_LENGTH = 32'd0;
    localparam logic [15:0] RESET_MAX_DISTANCE = 16'd32768;

    // entry word: bytes, position, valid
    localparam int ENTRY_BYTES_LO = 0;
    localparam int ENTRY_POS_LO   = 64;
    localparam int ENTRY_VALID    = 96;
    localparam int ENTRY_W        = 97;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 8'd1;

    localparam logic CMD_MATCH = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [0:0] {
        ST_CLEAR,
        ST_RUN
    } ctrl_state_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  length_or_literal;
    } result_t;

    typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

endpackage

// ===== rtl/lzhm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzhm_ram
// Single-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module lzhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lzhm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzhm_front
// Hash the substrings, pick one owner per bank, form row addresses and
// the entry words that the owners write back.
// ----------------------------------------------------------------------------
module lzhm_front #(
    parameter int SUBSTRING_BYTES = 8,
    parameter int BANK_COUNT      = 16,
    parameter int BANK_W          = 4,
    parameter int ROW_W           = 8
) (
    input  lzhm_pkg::window_t                                 win,
    input  logic [lzhm_pkg::POS_W-1:0]                        pos,
    output logic [lzhm_pkg::SUBSTRINGS-1:0][BANK_W-1:0]       sub_bank,
    output logic [BANK_COUNT-1:0]                             owned,
    output logic [BANK_COUNT-1:0][ROW_W-1:0]                  row,
    output logic [BANK_COUNT-1:0][lzhm_pkg::ENTRY_W-1:0]      wr_entry
);
    import lzhm_pkg::*;

    // split the hash into row and bank by a reciprocal multiply; with
    // HASH_W + BANK_W fraction bits the quotient is exact for every hash
    localparam int RECIP_SH = HASH_W + BANK_W;
    localparam int RECIP    = ((1 << RECIP_SH) + BANK_COUNT - 1) / BANK_COUNT;
    localparam int PROD_W   = HASH_W + RECIP_SH + 1;

    logic [SUBSTRINGS-1:0][HASH_W-1:0] hash;
    logic [SUBSTRINGS-1:0][PROD_W-1:0] quot_prod;
    logic [SUBSTRINGS-1:0][HASH_W-1:0] quot;
    logic [SUBSTRINGS-1:0][63:0]       packed_sub;

    always_comb
    begin
        for (int i = 0; i < SUBSTRINGS; i++)
        begin
            hash[i] = HASH_W'((({5'd0, win[i]}     << 5) ^ ({5'd0, win[i + 1]} << 4) ^
                               ({5'd0, win[i + 2]} << 3) ^ ({5'd0, win[i + 3]} << 2) ^
                               ({5'd0, win[i + 4]} << 1) ^  {5'd0, win[i + 5]})
                              & {1'b0, HASH_MASK});
            quot_prod[i] = PROD_W'(hash[i]) * PROD_W'(RECIP);
            quot[i]      = HASH_W'(quot_prod[i] >> RECIP_SH);
            sub_bank[i]  = BANK_W'(hash[i] - HASH_W'(quot[i] * HASH_W'(BANK_COUNT)));
            packed_sub[i] = '0;
            for (int k = 0; k < SUBSTRING_BYTES; k++)
            begin
                packed_sub[i][8*k +: 8] = win[i + k];
            end
        end
    end

    // lowest-indexed substring of each bank wins: scan from the top down
    always_comb
    begin
        for (int b = 0; b < BANK_COUNT; b++)
        begin
            owned[b]    = 1'b0;
            row[b]      = '0;
            wr_entry[b] = '0;
            for (int i = SUBSTRINGS - 1; i >= 0; i--)
            begin
                if (sub_bank[i] == BANK_W'(b))
                begin
                    owned[b] = 1'b1;
                    row[b]   = ROW_W'(quot[i]);
                    wr_entry[b][ENTRY_BYTES_LO +: 64]  = packed_sub[i];
                    wr_entry[b][ENTRY_POS_LO +: POS_W] = pos + POS_W'(i);
                    wr_entry[b][ENTRY_VALID]           = 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/lzhm_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzhm_match
// Compare each substring against the entry read from its bank and form
// a match or a literal.
// ----------------------------------------------------------------------------
module lzhm_match #(
    parameter int SUBSTRING_BYTES = 8,
    parameter int BANK_COUNT      = 16,
    parameter int BANK_W          = 4
) (
    input  lzhm_pkg::window_t                                 win,
    input  logic [lzhm_pkg::POS_W-1:0]                        pos,
    input  logic [lzhm_pkg::SUBSTRINGS-1:0][BANK_W-1:0]       sub_bank,
    input  logic [BANK_COUNT-1:0][lzhm_pkg::ENTRY_W-1:0]      cand,
    input  logic [31:0]                                       input_length,
    input  logic [15:0]                                       max_distance,
    output lzhm_pkg::result_t [lzhm_pkg::SUBSTRINGS-1:0]      res
);
    import lzhm_pkg::*;

    logic [SUBSTRINGS-1:0][ENTRY_W-1:0] sel;
    logic [SUBSTRINGS-1:0][3:0]         len;
    logic [SUBSTRINGS-1:0][POS_W-1:0]   gap;
    logic [SUBSTRINGS-1:0][POS_W:0]     end_pos;
    logic [SUBSTRINGS-1:0]              hit;
    logic [SUBSTRINGS-1:0]              run;

    always_comb
    begin
        for (int i = 0; i < SUBSTRINGS; i++)
        begin
            sel[i] = cand[sub_bank[i]];
            len[i] = '0;
            run[i] = 1'b1;
            for (int k = 0; k < SUBSTRING_BYTES; k++)
            begin
                if (run[i] && win[i + k] == sel[i][ENTRY_BYTES_LO + 8*k +: 8])
                begin
                    len[i] = len[i] + 4'd1;
                end
                else
                begin
                    run[i] = 1'b0;
                end
            end
            gap[i]     = pos + POS_W'(i) - sel[i][ENTRY_POS_LO +: POS_W];
            end_pos[i] = {1'b0, pos} + (POS_W + 1)'(i + SUBSTRING_BYTES - 1);
            hit[i] = (end_pos[i] < {1'b0, input_length}) && sel[i][ENTRY_VALID] &&
                     (len[i] >= 4'(MIN_MATCH)) && (gap[i] != '0) &&
                     (gap[i] <= {16'd0, max_distance});
            if (hit[i])
            begin
                res[i].length_or_literal = LEN_W'(len[i] - 4'(MIN_MATCH));
                res[i].distance          = gap[i][DIST_W-1:0];
            end
            else
            begin
                res[i].length_or_literal = win[i];
                res[i].distance          = '0;
            end
        end
    end

endmodule

// ===== rtl/lz77_parallel_hash_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_parallel_hash_matcher_core
// Banked hash-table matcher: eight substrings per window, one result each.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one window per item; tuser selects match (0) or clear (1).
//   m_axis returns eight results per match item, one per cycle while ready,
//   substring 0 first; tlast marks substring 7. A clear item returns nothing.
//   cfg writes input_length (index 0) and max_distance (index 1); always ready.
// Path: accepted item and bank reads -> stage 1 registers -> result buffer.
// Throughput: bound by the one-result-per-cycle output while m_axis_tready
//   is high; the table banks are read and written in the accept cycle, so a
//   new item enters while stage 1 is empty or as soon as the buffer frees up.
// Reset and clear: every row of the banks is swept to invalid, one row per
//   cycle across all banks, TABLE_ENTRIES/BANK_COUNT rows (256 by default);
//   s_axis_tready stays low meanwhile. A clear item starts the same sweep.
// Stall: while m_axis_tready is low the result buffer and the item behind it
//   hold, and s_axis_tready drops once both are full.
// ----------------------------------------------------------------------------
module lz77_parallel_hash_matcher_core #(
    parameter int SUBSTRING_BYTES = lzhm_pkg::DEF_SUBSTRING_BYTES,
    parameter int BANK_COUNT      = lzhm_pkg::DEF_BANK_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // window_low [63:0], window_high [127:64], window_position [159:128]
    input  logic [159:0]                       s_axis_tdata,
    // cmd [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // length_or_literal [7:0], distance [23:8]
    output logic [23:0]                        m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lzhm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data
);
    import lzhm_pkg::*;

    localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int ROWS   = (TABLE_ENTRIES + BANK_COUNT - 1) / BANK_COUNT;
    localparam int ROW_W  = $clog2(ROWS);

    window_t                            in_win;
    logic [POS_W-1:0]                   in_pos;
    logic [SUBSTRINGS-1:0][BANK_W-1:0]  in_bank;
    logic [BANK_COUNT-1:0]              owned;
    logic [BANK_COUNT-1:0][ROW_W-1:0]   row;
    logic [BANK_COUNT-1:0][ENTRY_W-1:0] wr_entry;
    logic [BANK_COUNT-1:0][ENTRY_W-1:0] cand;
    result_t [SUBSTRINGS-1:0]           res;

    ctrl_state_t state_reg, state_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic [31:0]      input_length_reg;
    logic [15:0]      max_distance_reg;

    window_t                           s1_win_reg;
    logic [POS_W-1:0]                  s1_pos_reg;
    logic [SUBSTRINGS-1:0][BANK_W-1:0] s1_bank_reg;
    logic                              s1_valid_reg;

    result_t [SUBSTRINGS-1:0] buf_reg;
    logic                     buf_valid_reg;
    logic [SUB_IDX_W-1:0]     cnt_reg;

    logic in_fire, match_fire, clear_fire, out_fire, buf_done, buf_free, s1_adv;

    assign in_win = window_t'(s_axis_tdata[127:0]);
    assign in_pos = s_axis_tdata[159:128];

    assign out_fire      = buf_valid_reg && m_axis_tready;
    assign buf_done      = out_fire && (cnt_reg == SUB_IDX_W'(SUBSTRINGS - 1));
    assign buf_free      = !buf_valid_reg || buf_done;
    assign s1_adv        = s1_valid_reg && buf_free;
    assign s_axis_tready = (state_reg == ST_RUN) && (!s1_valid_reg || buf_free);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign match_fire    = in_fire && (s_axis_tuser == CMD_MATCH);
    assign clear_fire    = in_fire && (s_axis_tuser == CMD_CLEAR);

    lzhm_front #(
        .SUBSTRING_BYTES (SUBSTRING_BYTES),
        .BANK_COUNT      (BANK_COUNT),
        .BANK_W          (BANK_W),
        .ROW_W           (ROW_W)
    ) u_front (
        .win      (in_win),
        .pos      (in_pos),
        .sub_bank (in_bank),
        .owned    (owned),
        .row      (row),
        .wr_entry (wr_entry)
    );

    // read and write back in the same cycle; the read returns the old word
    for (genvar b = 0; b < BANK_COUNT; b++)
    begin : g_bank
        logic             clearing;
        logic [ROW_W-1:0] addr;

        assign clearing = (state_reg == ST_CLEAR);
        assign addr     = clearing ? clr_row_reg : row[b];

        lzhm_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (ROWS)
        ) u_ram (
            .clk     (clk),
            .rd_en   (match_fire),
            .wr_en   (clearing || (match_fire && owned[b])),
            .addr    (addr),
            .wr_data (clearing ? {ENTRY_W{1'b0}} : wr_entry[b]),
            .rd_data (cand[b])
        );
    end

    lzhm_match #(
        .SUBSTRING_BYTES (SUBSTRING_BYTES),
        .BANK_COUNT      (BANK_COUNT),
        .BANK_W          (BANK_W)
    ) u_match (
        .win          (s1_win_reg),
        .pos          (s1_pos_reg),
        .sub_bank     (s1_bank_reg),
        .cand         (cand),
        .input_length (input_length_reg),
        .max_distance (max_distance_reg),
        .res          (res)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next   = ST_RUN;
                    clr_row_next = '0;
                end
            end
            ST_RUN:
            begin
                if (clear_fire)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_row_reg      <= '0;
            input_length_reg <= RESET_INPUT_LENGTH;
            max_distance_reg <= RESET_MAX_DISTANCE;
            s1_valid_reg     <= 1'b0;
            buf_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_INPUT_LENGTH)
                begin
                    input_length_reg <= cfg_data;
                end
                else if (cfg_index == REG_MAX_DISTANCE)
                begin
                    max_distance_reg <= cfg_data[15:0];
                end
            end
            if (match_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                buf_valid_reg <= 1'b1;
            end
            else if (buf_done)
            begin
                buf_valid_reg <= 1'b0;
            end
            if (out_fire)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_fire)
        begin
            s1_win_reg  <= in_win;
            s1_pos_reg  <= in_pos;
            s1_bank_reg <= in_bank;
        end
        if (s1_adv)
        begin
            buf_reg <= res;
        end
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = buf_valid_reg;
    assign m_axis_tdata  = buf_reg[cnt_reg];
    assign m_axis_tlast  = (cnt_reg == SUB_IDX_W'(SUBSTRINGS - 1));

`ifndef NO_ASSERTIONS
    a_ready_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == ST_RUN))
        else $error("input ready during table sweep");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clear_fire |=> (state_reg == ST_CLEAR) && (clr_row_reg == '0))
        else $error("clear item did not start sweep at row zero");

    a_pending_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !buf_free) |=> s1_valid_reg && $stable(s1_pos_reg))
        else $error("pending item lost while result buffer busy");
`endif

endmodule

// ===== verif/lz77_parallel_hash_matcher_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_parallel_hash_matcher_core_checker
// Watches the config, window and result channels, runs a banked hash-table
// match predictor on each accepted window and compares every result item.
// ----------------------------------------------------------------------------
module lz77_parallel_hash_matcher_core_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [159:0]                     s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [23:0]                      m_axis_tdata,
    input  logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [lzhm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               match_seen,
    output int                               result_seen
);
    import lzhm_pkg::*;

    localparam int BANKS = DEF_BANK_COUNT;

    typedef struct packed {
        logic [7:0]  length_or_literal;
        logic [15:0] distance;
        logic        last;
    } match_result_t;

    logic [63:0]       tbl_bytes [TABLE_ENTRIES];
    logic [31:0]       tbl_pos   [TABLE_ENTRIES];
    logic              tbl_valid [TABLE_ENTRIES];
    logic [31:0]       input_length;
    logic [15:0]       max_distance;
    match_result_t     expected_results [$];

    function automatic logic [HASH_W-1:0] hash6(window_t w, int s);
        logic [15:0] h;
        h = ({8'd0, w[s]} << 5) ^ ({8'd0, w[s+1]} << 4) ^ ({8'd0, w[s+2]} << 3) ^
            ({8'd0, w[s+3]} << 2) ^ ({8'd0, w[s+4]} << 1) ^ {8'd0, w[s+5]};
        return h[HASH_W-1:0];
    endfunction

    task automatic predict_window(window_t w, logic [31:0] pos);
        logic [HASH_W-1:0] hs [SUBSTRINGS];
        int                owner [BANKS];
        logic [63:0]       cb [BANKS];
        logic [31:0]       cp [BANKS];
        logic              cv [BANKS];
        int                bk, len;
        logic [31:0]       gap;
        logic [32:0]       last_byte;
        logic [63:0]       sub;
        match_result_t     r;
        for (int b = 0; b < BANKS; b++)
        begin
            owner[b] = SUBSTRINGS;
            cb[b] = '0;
            cp[b] = '0;
            cv[b] = 1'b0;
        end
        for (int i = 0; i < SUBSTRINGS; i++)
        begin
            hs[i] = hash6(w, i);
            bk = hs[i] % BANKS;
            if (owner[bk] == SUBSTRINGS)
                owner[bk] = i;
        end
        // all bank reads of the window happen before any write
        for (int b = 0; b < BANKS; b++)
        begin
            if (owner[b] != SUBSTRINGS)
            begin
                cb[b] = tbl_bytes[hs[owner[b]]];
                cp[b] = tbl_pos[hs[owner[b]]];
                cv[b] = tbl_valid[hs[owner[b]]];
            end
        end
        for (int b = 0; b < BANKS; b++)
        begin
            if (owner[b] != SUBSTRINGS)
            begin
                for (int k = 0; k < 8; k++)
                    sub[8*k +: 8] = w[owner[b] + k];
                tbl_bytes[hs[owner[b]]] = sub;
                tbl_pos[hs[owner[b]]]   = pos + owner[b];
                tbl_valid[hs[owner[b]]] = 1'b1;
            end
        end
        for (int i = 0; i < SUBSTRINGS; i++)
        begin
            bk = hs[i] % BANKS;
            len = 0;
            while (len < DEF_SUBSTRING_BYTES && w[i+len] == cb[bk][8*len +: 8])
                len++;
            gap = pos + i - cp[bk];
            last_byte = {1'b0, pos} + i + DEF_SUBSTRING_BYTES - 1;
            if (last_byte < {1'b0, input_length} && cv[bk] && len >= MIN_MATCH &&
                gap >= 1 && gap <= {16'd0, max_distance})
            begin
                r.length_or_literal = len - MIN_MATCH;
                r.distance = gap[15:0];
            end
            else
            begin
                r.length_or_literal = w[i];
                r.distance = '0;
            end
            r.last = (i == SUBSTRINGS - 1);
            expected_results.push_back(r);
        end
    endtask

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        match_result_t exp_r;
        match_result_t got;
        if (!rst_n)
        begin
            for (int e = 0; e < TABLE_ENTRIES; e++)
                tbl_valid[e] = 1'b0;
            input_length <= RESET_INPUT_LENGTH;
            max_distance <= RESET_MAX_DISTANCE;
            fail_count   <= 0;
            match_seen   <= 0;
            result_seen  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_INPUT_LENGTH)
                    input_length <= cfg_data;
                else if (cfg_index == REG_MAX_DISTANCE)
                    max_distance <= cfg_data[15:0];
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast};
                result_seen <= result_seen + 1;
                if (got.distance != 0)
                    match_seen <= match_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result item: expected none, actual %h",
                             $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.length_or_literal != exp_r.length_or_literal ||
                        got.distance != exp_r.distance || got.last != exp_r.last)
                    begin
                        $display("%0t: mismatch: expected %h/%0d/%b, actual %h/%0d/%b",
                                 $time, exp_r.length_or_literal, exp_r.distance,
                                 exp_r.last, got.length_or_literal, got.distance,
                                 got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == CMD_CLEAR)
                begin
                    for (int e = 0; e < TABLE_ENTRIES; e++)
                        tbl_valid[e] = 1'b0;
                end
                else
                    predict_window(s_axis_tdata[127:0], s_axis_tdata[159:128]);
            end
        end
    end

endmodule

// ===== verif/lz77_parallel_hash_matcher_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_parallel_hash_matcher_core_tb
// Drives windows, clear commands and register writes into the matcher under
// random backpressure; the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module lz77_parallel_hash_matcher_core_tb;
    import lzhm_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [159:0]           s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [23:0]            m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    int                     fail_count;
    int                     pending;
    int                     match_seen;
    int                     result_seen;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     window_count;
    logic [127:0]           source_text;

    lz77_parallel_hash_matcher_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lz77_parallel_hash_matcher_core_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .match_seen(match_seen), .result_seen(result_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("lz77_parallel_hash_matcher_core_tb: FAIL");
        $finish;
    end

    // receiver stalls at random
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // hold tvalid high from one item into the next; drop it only to idle
    task automatic send_item(logic cmd, logic [127:0] win, logic [31:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {pos, win};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        window_count++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // window of random letters from a small alphabet so that substrings recur
    function automatic logic [127:0] text_window(int alphabet);
        logic [127:0] w;
        for (int k = 0; k < 16; k++)
            w[8*k +: 8] = 8'h41 + $urandom_range(alphabet - 1);
        return w;
    endfunction

    task automatic random_phase(int count, int spread);
        logic [31:0] pos;
        logic [127:0] w;
        pos = $urandom_range(64);
        w = text_window(2);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0: send_item(CMD_MATCH, {$urandom, $urandom, $urandom, $urandom},
                             {$urandom});
                1: if ($urandom_range(3) == 0) send_item(CMD_CLEAR, {4{$urandom}}, $urandom);
                2: w = text_window(2 + $urandom_range(3));
                default:
                begin
                    // slide a repeating pattern forward so older copies match
                    pos = pos + $urandom_range(spread);
                    if ($urandom_range(1)) w = {w[119:0], w[127:120]};
                    send_item(CMD_MATCH, w, pos);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_MATCH;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_INPUT_LENGTH;
        cfg_data      = '0;
        send_idle_pct = 35;
        recv_idle_pct = 82;
        window_count  = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset registers: input length zero, so everything is a literal
        source_text = "abcabcabcabcabca";
        send_item(CMD_MATCH, source_text, 32'd0);
        send_item(CMD_MATCH, source_text, 32'd3);
        drain();
        write_reg(REG_INPUT_LENGTH, 32'hffff_ffff);
        write_reg(8'd7, 32'd5);
        send_item(CMD_MATCH, source_text, 32'd10);
        send_item(CMD_MATCH, source_text, 32'd13);
        send_item(CMD_MATCH, source_text, 32'd13);
        send_item(CMD_MATCH, '0, 32'd0);
        send_item(CMD_MATCH, '1, 32'hffff_fff0);
        send_item(CMD_MATCH, '1, 32'hffff_fff8);
        send_item(CMD_MATCH, '0, 32'hffff_fff8);
        send_item(CMD_MATCH, '0, 32'd9);
        send_item(CMD_CLEAR, '1, 32'hffff_ffff);
        send_item(CMD_MATCH, source_text, 32'd30);
        drain();
        write_reg(REG_MAX_DISTANCE, 32'd0);
        send_item(CMD_MATCH, source_text, 32'd40);
        send_item(CMD_MATCH, source_text, 32'd43);
        drain();
        write_reg(REG_MAX_DISTANCE, 32'd1);
        send_item(CMD_MATCH, '0, 32'd50);
        send_item(CMD_MATCH, '0, 32'd51);
        drain();
        write_reg(REG_MAX_DISTANCE, 32'hffff);
        write_reg(REG_INPUT_LENGTH, 32'd80);
        send_item(CMD_MATCH, source_text, 32'd60);
        send_item(CMD_MATCH, source_text, 32'd66);
        send_item(CMD_MATCH, {$urandom, $urandom, $urandom, $urandom}, 32'd70);
        drain();

        write_reg(REG_INPUT_LENGTH, 32'hffff_ffff);
        write_reg(REG_MAX_DISTANCE, 32'd64);
        random_phase(60, 12);
        drain();
        send_idle_pct = 82;
        recv_idle_pct = 35;
        write_reg(REG_MAX_DISTANCE, 32'hffff);
        write_reg(REG_INPUT_LENGTH, 32'd400 + $urandom_range(400));
        random_phase(60, 20);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MAX_DISTANCE, 32'd8 + $urandom_range(32));
        write_reg(REG_INPUT_LENGTH, $urandom);
        random_phase(50, 8);

        drain();
        $display("Covered %0d input items, %0d result items, %0d of them matches,",
                 window_count, result_seen, match_seen);
        $display("across several register settings, clears and backpressure mixes.");
        if (fail_count == 0)
            $display("lz77_parallel_hash_matcher_core_tb: PASS");
        else
            $display("lz77_parallel_hash_matcher_core_tb: FAIL");
        $finish;
    end

endmodule
